// ===== rtl/first_fit_chunk_allocator_core_defines.svh =====
// assertion macros for the first-fit chunk allocator
// expects clk and rst_n in the scope of the module that uses them
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define FFCA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define FFCA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFCA_ASSERT(lbl, prop, msg)
`define FFCA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/ffca_pkg.sv =====
// shared constants, codes and types of the first-fit chunk allocator
// no dependencies
`default_nettype none

package ffca_pkg;

    localparam int NUM_CHUNKS_DEF = 28;

    localparam int ADDR_W      = 32;
    localparam int CHUNK_SHIFT = 10;
    localparam int HI_W        = ADDR_W - CHUNK_SHIFT;
    localparam int CFG_W       = 30;
    localparam int BASE_W      = CFG_W - CHUNK_SHIFT;
    localparam int ENTRY_W     = 6;
    localparam int MASK_W      = 32;
    localparam int BIT_W       = $clog2(MASK_W);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [ENTRY_W-1:0] ENTRY_FREE = 6'd0;
    localparam logic [ENTRY_W-1:0] ENTRY_CONT = 6'd63;

    localparam logic [ADDR_W-1:0] SRAM_START = 32'h2000_0000;
    localparam logic [ADDR_W-1:0] WINDOW_END = 32'h2000_8000;

    // chunk numbers, one bit wider than an address without its offset
    localparam logic [HI_W:0] SRAM_CHUNK   = (HI_W+1)'(SRAM_START >> CHUNK_SHIFT);
    localparam logic [HI_W:0] WINDOW_CHUNK = (HI_W+1)'(WINDOW_END >> CHUNK_SHIFT);

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(SRAM_START >> CHUNK_SHIFT);
    localparam logic [MASK_W-1:0] MASK_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              success;
        logic [ADDR_W-1:0] block_address;
        logic [MASK_W-1:0] access_mask;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/ffca_unit.sv =====
// shared add / subtract unit over chunk numbers
// depends on ffca_pkg
`default_nettype none

module ffca_unit
(
    input  wire logic [ffca_pkg::HI_W-1:0] a,
    input  wire logic [ffca_pkg::HI_W-1:0] b,
    input  wire logic                      sub,
    output logic      [ffca_pkg::HI_W:0]   res
);

    logic [ffca_pkg::HI_W-1:0] b_eff;

    // on subtract the top bit is the carry out, set when a >= b
    assign b_eff = sub ? ~b : b;
    assign res   = {1'b0, a} + {1'b0, b_eff} + (ffca_pkg::HI_W+1)'(sub);

endmodule

`default_nettype wire

// ===== rtl/ffca_table.sv =====
// chunk table: one run-length or continuation code per chunk
// depends on ffca_pkg
`default_nettype none

module ffca_table #(
    parameter int NUM_CHUNKS = ffca_pkg::NUM_CHUNKS_DEF,
    localparam int IW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [IW-1:0]                rd_idx,
    output logic      [ffca_pkg::ENTRY_W-1:0] rd_data,
    input  wire logic                         wr_en,
    input  wire logic [IW-1:0]                wr_idx,
    input  wire logic [ffca_pkg::ENTRY_W-1:0] wr_data
);

    logic [ffca_pkg::ENTRY_W-1:0] entry_reg [NUM_CHUNKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHUNKS; i++)
            begin
                entry_reg[i] <= ffca_pkg::ENTRY_FREE;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/ffca_seq.sv =====
// sequencer: size rounding, first-fit scan, run marking and release, mask upkeep
// depends on ffca_pkg, ffca_unit and the assertion macro header
`default_nettype none
`include "first_fit_chunk_allocator_core_defines.svh"

module ffca_seq #(
    parameter int NUM_CHUNKS = ffca_pkg::NUM_CHUNKS_DEF,
    localparam int IW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           op,
    input  wire logic [ffca_pkg::ADDR_W-1:0]    alloc_size,
    input  wire logic [ffca_pkg::ADDR_W-1:0]    free_address,
    input  wire logic [ffca_pkg::BASE_W-1:0]    heap_base,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output ffca_pkg::res_t                      res,
    output logic      [IW-1:0]                  tbl_rd_idx,
    input  wire logic [ffca_pkg::ENTRY_W-1:0]   tbl_rd_data,
    output logic                                tbl_wr_en,
    output logic      [IW-1:0]                  tbl_wr_idx,
    output logic      [ffca_pkg::ENTRY_W-1:0]   tbl_wr_data
);

    localparam int CW = $clog2(NUM_CHUNKS + 1);
    localparam int HW = ffca_pkg::HI_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SIZE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_MARK  = 4'd3;
    localparam logic [3:0] S_ADDR  = 4'd4;
    localparam logic [3:0] S_FIND  = 4'd5;
    localparam logic [3:0] S_FREAD = 4'd6;
    localparam logic [3:0] S_FCLR  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                    state_reg, state_next;
    logic [HW-1:0]                 hi_reg, hi_next;
    logic                          lo_nz_reg, lo_nz_next;
    logic                          zero_reg, zero_next;
    logic [CW-1:0]                 need_reg, need_next;
    logic [CW-1:0]                 run_reg, run_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic [IW-1:0]                 c_reg, c_next;
    logic [IW-1:0]                 first_reg, first_next;
    logic                          flag_reg, flag_next;
    logic                          success_reg, success_next;
    logic [ffca_pkg::ADDR_W-1:0]   block_reg, block_next;
    logic [ffca_pkg::MASK_W-1:0]   mask_reg, mask_next;

    logic [HW-1:0]                 unit_a;
    logic [HW-1:0]                 unit_b;
    logic                          unit_sub;
    logic [HW:0]                   unit_res;

    logic                          take;
    logic                          ge_sram;
    logic                          in_window;
    logic                          mask_apply;
    logic [ffca_pkg::BIT_W-1:0]    mask_bit;
    logic [CW-1:0]                 run_inc;
    logic                          entry_free;

    ffca_unit u_unit (
        .a   (unit_a),
        .b   (unit_b),
        .sub (unit_sub),
        .res (unit_res)
    );

    // operand selection for the shared unit
    always_comb
    begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
        case (state_reg)
            S_SIZE:
            begin
                unit_a = hi_reg;
                unit_b = HW'(lo_nz_reg);
            end
            S_FIND:
            begin
                unit_a   = hi_reg;
                unit_b   = HW'(heap_base);
                unit_sub = 1'b1;
            end
            S_MARK, S_FCLR:
            begin
                unit_a = HW'(heap_base);
                unit_b = HW'(c_reg);
            end
            S_ADDR:
            begin
                unit_a = HW'(heap_base);
                unit_b = HW'(first_reg);
            end
            default:
            begin
                unit_a = '0;
            end
        endcase
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign take       = in_valid && !in_stall;
    assign res_valid  = (state_reg == S_DONE);
    assign res        = '{success: success_reg, block_address: block_reg,
                          access_mask: mask_reg};
    assign tbl_rd_idx = c_reg;

    // chunk number of the current chunk against the mask window
    assign ge_sram    = (unit_res >= ffca_pkg::SRAM_CHUNK);
    assign in_window  = ge_sram && (unit_res < ffca_pkg::WINDOW_CHUNK);
    // the run's first chunk decides whether the mask is touched at all
    assign mask_apply = in_window && ((k_reg == '0) || flag_reg);
    // window start is a multiple of 32 chunks, so the low bits are the bit index
    assign mask_bit   = unit_res[ffca_pkg::BIT_W-1:0];

    assign run_inc    = run_reg + CW'(1);
    assign entry_free = (tbl_rd_data == ffca_pkg::ENTRY_FREE);

    always_comb
    begin
        state_next   = state_reg;
        hi_next      = hi_reg;
        lo_nz_next   = lo_nz_reg;
        zero_next    = zero_reg;
        need_next    = need_reg;
        run_next     = run_reg;
        k_next       = k_reg;
        c_next       = c_reg;
        first_next   = first_reg;
        flag_next    = flag_reg;
        success_next = success_reg;
        block_next   = block_reg;
        mask_next    = mask_reg;
        tbl_wr_en    = 1'b0;
        tbl_wr_idx   = c_reg;
        tbl_wr_data  = ffca_pkg::ENTRY_FREE;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    success_next = 1'b0;
                    block_next   = '0;
                    lo_nz_next   = |alloc_size[ffca_pkg::CHUNK_SHIFT-1:0];
                    if (op == ffca_pkg::OP_FREE)
                    begin
                        hi_next    = free_address[ffca_pkg::ADDR_W-1:ffca_pkg::CHUNK_SHIFT];
                        zero_next  = (free_address == '0);
                        state_next = S_FIND;
                    end
                    else
                    begin
                        hi_next    = alloc_size[ffca_pkg::ADDR_W-1:ffca_pkg::CHUNK_SHIFT];
                        zero_next  = (alloc_size == '0);
                        state_next = S_SIZE;
                    end
                end
            end

            // round up to whole chunks; a zero size or more chunks than the table holds ends the request
            S_SIZE:
            begin
                if (zero_reg || (unit_res > (HW+1)'(NUM_CHUNKS)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    need_next  = unit_res[CW-1:0];
                    run_next   = '0;
                    c_next     = '0;
                    state_next = S_SCAN;
                end
            end

            // one entry a cycle, tracking the length of the free run ending here
            S_SCAN:
            begin
                if (entry_free && (run_inc == need_reg))
                begin
                    first_next = c_reg - IW'(run_reg);
                    c_next     = c_reg - IW'(run_reg);
                    k_next     = '0;
                    state_next = S_MARK;
                end
                else if (c_reg == IW'(NUM_CHUNKS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    run_next = entry_free ? run_inc : '0;
                    c_next   = c_reg + IW'(1);
                end
            end

            S_MARK:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_data = (k_reg == '0) ? ffca_pkg::ENTRY_W'(need_reg)
                                            : ffca_pkg::ENTRY_CONT;
                if (k_reg == '0)
                begin
                    flag_next = ge_sram;
                end
                if (mask_apply)
                begin
                    mask_next[mask_bit] = 1'b0;
                end
                if (k_reg == need_reg - CW'(1))
                begin
                    state_next = S_ADDR;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    c_next = c_reg + IW'(1);
                end
            end

            S_ADDR:
            begin
                success_next = 1'b1;
                block_next   = {unit_res[HW-1:0], ffca_pkg::CHUNK_SHIFT'(0)};
                state_next   = S_DONE;
            end

            // address minus base in chunks, must land inside the heap
            S_FIND:
            begin
                if (!zero_reg && unit_res[HW] && (unit_res[HW-1:0] < HW'(NUM_CHUNKS)))
                begin
                    c_next     = unit_res[IW-1:0];
                    state_next = S_FREAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FREAD:
            begin
                if (entry_free || (tbl_rd_data == ffca_pkg::ENTRY_CONT))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    need_next  = tbl_rd_data[CW-1:0];
                    k_next     = '0;
                    state_next = S_FCLR;
                end
            end

            S_FCLR:
            begin
                tbl_wr_en   = ({1'b0, c_reg} < (IW+1)'(NUM_CHUNKS));
                tbl_wr_data = ffca_pkg::ENTRY_FREE;
                if (k_reg == '0)
                begin
                    flag_next = ge_sram;
                end
                if (mask_apply)
                begin
                    mask_next[mask_bit] = 1'b1;
                end
                if (k_reg == need_reg - CW'(1))
                begin
                    success_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    c_next = c_reg + IW'(1);
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mask_reg  <= ffca_pkg::MASK_RESET;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        lo_nz_reg   <= lo_nz_next;
        zero_reg    <= zero_next;
        need_reg    <= need_next;
        run_reg     <= run_next;
        k_reg       <= k_next;
        c_reg       <= c_next;
        first_reg   <= first_next;
        flag_reg    <= flag_next;
        success_reg <= success_next;
        block_reg   <= block_next;
    end

    `FFCA_ASSERT_ALWAYS(a_wr_only_in_update, tbl_wr_en |-> ((state_reg == S_MARK) || (state_reg == S_FCLR)), "chunk table written outside a run update")
    `FFCA_ASSERT(a_take_leaves_idle, take |=> (state_reg != S_IDLE), "accepted transaction not started")
    `FFCA_ASSERT(a_alloc_only_grants, (state_reg == S_MARK) |=> ((mask_reg | $past(mask_reg)) == $past(mask_reg)), "allocate revoked access")
    `FFCA_ASSERT(a_free_only_revokes, (state_reg == S_FCLR) |=> ((mask_reg & $past(mask_reg)) == $past(mask_reg)), "free granted access")
    `FFCA_ASSERT(a_mark_in_table, (state_reg == S_MARK) |-> ({1'b0, c_reg} < (IW+1)'(NUM_CHUNKS)), "run marking beyond the table")

endmodule

`default_nettype wire

// ===== rtl/first_fit_chunk_allocator_core.sv =====
// allocate: rounds the size up to chunks, finds the first free run that fits, marks it
// free: clears the run that starts at the address; outside the heap or off a run start it fails
// one transaction in flight; the next is taken as soon as the result sits in the output register
// sequencer, table scan and marking all step through the chunk table one entry a cycle
// reset clears the chunk table, sets the access mask to all ones and the base to 0x20000000
// no clearing pass after reset
`default_nettype none
`include "first_fit_chunk_allocator_core_defines.svh"

module first_fit_chunk_allocator_core #(
    parameter int NUM_CHUNKS = ffca_pkg::NUM_CHUNKS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic [ffca_pkg::ADDR_W-1:0]   alloc_size,
    input  wire logic [ffca_pkg::ADDR_W-1:0]   free_address,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               success,
    output logic      [ffca_pkg::ADDR_W-1:0]   block_address,
    output logic      [ffca_pkg::MASK_W-1:0]   access_mask,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ffca_pkg::CFG_W-1:0]    cfg_wr_data
);

    localparam int IW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    logic [ffca_pkg::BASE_W-1:0]  base_reg;
    logic                         out_valid_reg;
    ffca_pkg::res_t               out_reg;
    logic                         res_valid;
    logic                         res_ready;
    ffca_pkg::res_t               res;
    logic [IW-1:0]                tbl_rd_idx;
    logic [ffca_pkg::ENTRY_W-1:0] tbl_rd_data;
    logic                         tbl_wr_en;
    logic [IW-1:0]                tbl_wr_idx;
    logic [ffca_pkg::ENTRY_W-1:0] tbl_wr_data;

    // only whole chunks count, the offset bits of the base are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= ffca_pkg::BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data[ffca_pkg::CFG_W-1:ffca_pkg::CHUNK_SHIFT];
        end
    end

    ffca_table #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (tbl_rd_idx),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_idx  (tbl_wr_idx),
        .wr_data (tbl_wr_data)
    );

    ffca_seq #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .alloc_size   (alloc_size),
        .free_address (free_address),
        .heap_base    (base_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .tbl_rd_idx   (tbl_rd_idx),
        .tbl_rd_data  (tbl_rd_data),
        .tbl_wr_en    (tbl_wr_en),
        .tbl_wr_idx   (tbl_wr_idx),
        .tbl_wr_data  (tbl_wr_data)
    );

    // output register frees up in the same cycle its transaction completes
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign success       = out_reg.success;
    assign block_address = out_reg.block_address;
    assign access_mask   = out_reg.access_mask;

    `FFCA_ASSERT(a_result_not_lost, (res_valid && !res_ready) |=> res_valid, "result dropped while output held")

endmodule

`default_nettype wire
